FILE: src/upte_pkg.sv
// Shared types, constants and codes for the UDP payload tag extractor.
package upte_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 65535;
    localparam int FIFO_DEPTH          = 4;
    localparam int TAG_LEN             = 4;
    localparam int TAG_CELLS           = TAG_LEN - 1;

    localparam logic [1:0] KIND_CAPTURE = 2'd0;
    localparam logic [1:0] KIND_CLOSE   = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [3:0]  MIN_IHL        = 4'd5;
    localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;
    localparam logic [7:0]  CLOSE_BRACE    = 8'h7D;

    localparam int OFF_ETYPE_HI = 12;
    localparam int OFF_ETYPE_LO = 13;
    localparam int OFF_IHL      = 14;
    localparam int OFF_PROTO    = 23;

    // UDP header fields, relative to the start of the UDP header
    localparam logic [2:0] REL_SPORT_HI = 3'd0;
    localparam logic [2:0] REL_SPORT_LO = 3'd1;
    localparam logic [2:0] REL_ULEN_HI  = 3'd4;
    localparam logic [2:0] REL_ULEN_LO  = 3'd5;

    localparam logic [6:0] UDP_HDR_BASE = 7'd14;
    localparam logic [6:0] PAYLOAD_BASE = 7'd22;
    localparam logic [6:0] UDP_HDR_LEN7 = 7'd8;

    localparam logic [7:0] TAG_TEXT [TAG_LEN] = '{8'h53, 8'h45, 8'h47, 8'h7B};

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       first_of_frame;
        logic       last_of_frame;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  captured_byte;
        logic [15:0] segment_length;
        logic [15:0] source_port;
        logic        frame_is_udp;
        logic [15:0] frame_segments;
        logic        capture_abandoned;
        logic [31:0] total_segments;
        logic [31:0] total_udp_frames;
        logic        last_of_run;
    } out_beat_t;

    typedef struct packed {
        logic advance;  // a beat is taken this cycle
        logic flush;    // frame restarts before this byte
        logic shift;    // byte enters the matcher
        logic clear;    // empty the matcher after this byte
    } cell_ctrl_t;

endpackage

FILE: src/upte_cell.sv
// One stage of the tag matcher chain: holds a byte and compares it to its tag character.
module upte_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  upte_pkg::cell_ctrl_t   ctrl,
    input  logic [7:0]             din_byte,
    input  logic                   din_valid,
    input  logic [7:0]             exp_char,
    output logic [7:0]             cur_byte,
    output logic                   cur_valid,
    output logic                   hit
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       valid_reg;
    logic       valid_next;

    always_comb begin
        cur_byte  = byte_reg;
        cur_valid = valid_reg && !ctrl.flush;
        hit       = cur_valid && (cur_byte == exp_char);

        byte_next  = byte_reg;
        valid_next = valid_reg;
        if (ctrl.advance) begin
            if (ctrl.clear) begin
                valid_next = 1'b0;
            end else if (ctrl.shift) begin
                byte_next  = din_byte;
                valid_next = din_valid;
            end else begin
                valid_next = cur_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        byte_reg <= byte_next;
    end

endmodule

FILE: src/upte_out_fifo.sv
// Result queue: takes up to two results per cycle, delivers one per cycle while m_ready is high.
module upte_out_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [1:0]            push_count,
    input  upte_pkg::out_beat_t   push_data0,
    input  upte_pkg::out_beat_t   push_data1,
    output logic                  room,
    output logic                  m_valid,
    input  logic                  m_ready,
    output upte_pkg::out_beat_t   m_data
);

    localparam int PTR_W = $clog2(upte_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(upte_pkg::FIFO_DEPTH + 1);

    upte_pkg::out_beat_t mem [upte_pkg::FIFO_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;

    always_comb begin
        m_valid     = (count_reg != '0);
        m_data      = mem[rd_ptr_reg];
        room        = (count_reg <= CNT_W'(upte_pkg::FIFO_DEPTH - 2));
        pop         = m_valid && m_ready;
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_count) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            mem[wr_ptr_reg] <= push_data0;
        end
        if (push_count == 2'd2) begin
            mem[wr_ptr_reg + PTR_W'(1)] <= push_data1;
        end
    end

endmodule

FILE: src/udp_payload_tag_extractor_unit.sv
// Top level: Ethernet/IPv4/UDP header parse, tag matcher chain and result queue.
// A result is written into the result queue when its byte is taken and is offered on m_data from the queue head.
// Throughput: one byte per cycle while s_ready is high; a byte that yields two results (frame end)
// pushes both into the four-entry result queue at once.
// s_ready drops only while the queue holds more than two results.
// Reset (aresetn low, synchronous) clears all frame state, totals and the queue.
module udp_payload_tag_extractor_unit #(
    parameter int MAX_FRAME_BYTES = upte_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  upte_pkg::in_beat_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output upte_pkg::out_beat_t  m_data
);

    localparam int OFF_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W = (OFF_W > 8) ? OFF_W : 8;
    localparam int NC    = upte_pkg::TAG_CELLS;

    logic [OFF_W-1:0] byte_offset_reg,  byte_offset_next;
    logic [15:0]      ether_type_reg,   ether_type_next;
    logic [3:0]       header_words_reg, header_words_next;
    logic [7:0]       ip_protocol_reg,  ip_protocol_next;
    logic [15:0]      udp_length_reg,   udp_length_next;
    logic [15:0]      src_port_reg,     src_port_next;
    logic             in_segment_reg,   in_segment_next;
    logic [15:0]      open_length_reg,  open_length_next;
    logic [15:0]      seg_in_frame_reg, seg_in_frame_next;
    logic [31:0]      seg_total_reg,    seg_total_next;
    logic [31:0]      udp_total_reg,    udp_total_next;

    logic             accept;
    logic             first;
    logic             last;
    logic [7:0]       b;
    logic [OFF_W-1:0] cur_off;
    logic             in_range;
    logic [6:0]       udp_start;
    logic [6:0]       pay_start;
    logic [6:0]       pay_start_end;
    logic [CMP_W-1:0] off_c;
    logic [CMP_W-1:0] pay_idx;
    logic [2:0]       rel;
    logic             ip_ok;
    logic             in_pay;
    logic             is_udp;
    logic             tag_open;
    logic             has_a;

    upte_pkg::cell_ctrl_t cell_ctrl;
    logic [7:0]           cell_byte  [NC];
    logic                 cell_valid [NC];
    logic                 cell_hit   [NC];

    upte_pkg::out_beat_t res_a;
    upte_pkg::out_beat_t res_sum;
    upte_pkg::out_beat_t push_data0;
    logic [1:0]          push_count;
    logic                room;

    assign s_ready = room;

    // matcher chain: stage 0 holds the newest payload byte
    for (genvar i = 0; i < NC; i++) begin : g_chain
        if (i == 0) begin : g_head
            upte_cell u_stage (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (cell_ctrl),
                .din_byte  (b),
                .din_valid (1'b1),
                .exp_char  (upte_pkg::TAG_TEXT[NC-1-i]),
                .cur_byte  (cell_byte[i]),
                .cur_valid (cell_valid[i]),
                .hit       (cell_hit[i])
            );
        end else begin : g_body
            upte_cell u_stage (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (cell_ctrl),
                .din_byte  (cell_byte[i-1]),
                .din_valid (cell_valid[i-1]),
                .exp_char  (upte_pkg::TAG_TEXT[NC-1-i]),
                .cur_byte  (cell_byte[i]),
                .cur_valid (cell_valid[i]),
                .hit       (cell_hit[i])
            );
        end
    end

    always_comb begin
        accept = s_valid && s_ready;
        first  = s_data.first_of_frame;
        last   = s_data.last_of_frame;
        b      = s_data.frame_byte;

        // frame start clears the per-frame view before this byte is used
        byte_offset_next  = first ? '0 : byte_offset_reg;
        ether_type_next   = first ? '0 : ether_type_reg;
        header_words_next = first ? '0 : header_words_reg;
        ip_protocol_next  = first ? '0 : ip_protocol_reg;
        udp_length_next   = first ? '0 : udp_length_reg;
        src_port_next     = first ? '0 : src_port_reg;
        in_segment_next   = first ? 1'b0 : in_segment_reg;
        open_length_next  = first ? '0 : open_length_reg;
        seg_in_frame_next = first ? '0 : seg_in_frame_reg;
        seg_total_next    = seg_total_reg;
        udp_total_next    = udp_total_reg;

        cur_off   = byte_offset_next;
        in_range  = (cur_off < OFF_W'(MAX_FRAME_BYTES));
        // header offsets use the IHL held before this byte
        udp_start = upte_pkg::UDP_HDR_BASE + {1'b0, header_words_next, 2'b00};
        pay_start = udp_start + upte_pkg::UDP_HDR_LEN7;
        off_c     = CMP_W'(cur_off);
        rel       = 3'(off_c - CMP_W'(udp_start));
        pay_idx   = off_c - CMP_W'(pay_start);
        ip_ok     = 1'b0;
        in_pay    = 1'b0;
        tag_open  = 1'b0;
        has_a     = 1'b0;

        res_a            = '0;
        res_a.frame_is_udp = 1'b1;
        res_a.last_of_run  = !last;

        if (in_range) begin
            if (cur_off == OFF_W'(upte_pkg::OFF_ETYPE_HI)) begin
                ether_type_next[15:8] = b;
            end else if (cur_off == OFF_W'(upte_pkg::OFF_ETYPE_LO)) begin
                ether_type_next[7:0] = b;
            end else if (cur_off == OFF_W'(upte_pkg::OFF_IHL)) begin
                header_words_next = b[3:0];
            end else if (cur_off == OFF_W'(upte_pkg::OFF_PROTO)) begin
                ip_protocol_next = b;
            end

            if (header_words_next >= upte_pkg::MIN_IHL && off_c >= CMP_W'(udp_start)
                    && off_c < CMP_W'(pay_start)) begin
                case (rel)
                    upte_pkg::REL_SPORT_HI: src_port_next[15:8]   = b;
                    upte_pkg::REL_SPORT_LO: src_port_next[7:0]    = b;
                    upte_pkg::REL_ULEN_HI:  udp_length_next[15:8] = b;
                    upte_pkg::REL_ULEN_LO:  udp_length_next[7:0]  = b;
                    default: ;
                endcase
            end

            ip_ok  = (ether_type_next == upte_pkg::ETHERTYPE_IPV4)
                  && (ip_protocol_next == upte_pkg::PROTO_UDP)
                  && (header_words_next >= upte_pkg::MIN_IHL);
            in_pay = ip_ok && off_c >= CMP_W'(pay_start)
                  && udp_length_next >= upte_pkg::UDP_HDR_BYTES
                  && 16'(pay_idx) < (udp_length_next - upte_pkg::UDP_HDR_BYTES);

            if (in_pay) begin
                if (in_segment_next) begin
                    has_a = 1'b1;
                    if (b == upte_pkg::CLOSE_BRACE) begin
                        res_a.result_kind    = upte_pkg::KIND_CLOSE;
                        res_a.segment_length = open_length_next;
                        in_segment_next      = 1'b0;
                        open_length_next     = '0;
                        if (seg_in_frame_next != '1) begin
                            seg_in_frame_next = seg_in_frame_next + 16'd1;
                        end
                        if (seg_total_next != '1) begin
                            seg_total_next = seg_total_next + 32'd1;
                        end
                    end else begin
                        res_a.result_kind   = upte_pkg::KIND_CAPTURE;
                        res_a.captured_byte = b;
                        if (open_length_next != '1) begin
                            open_length_next = open_length_next + 16'd1;
                        end
                    end
                end else begin
                    tag_open = (b == upte_pkg::TAG_TEXT[NC]) && cell_hit[0]
                            && cell_hit[1] && cell_hit[2];
                    if (tag_open) begin
                        in_segment_next  = 1'b1;
                        open_length_next = '0;
                    end
                end
            end
            byte_offset_next = cur_off + OFF_W'(1);
        end

        // frame summary uses the IHL as updated by this byte
        pay_start_end = upte_pkg::PAYLOAD_BASE + {1'b0, header_words_next, 2'b00};
        ip_ok  = (ether_type_next == upte_pkg::ETHERTYPE_IPV4)
              && (ip_protocol_next == upte_pkg::PROTO_UDP)
              && (header_words_next >= upte_pkg::MIN_IHL);
        is_udp = ip_ok && (CMP_W'(byte_offset_next) >= CMP_W'(pay_start_end));
        if (last && is_udp && udp_total_next != '1) begin
            udp_total_next = udp_total_next + 32'd1;
        end

        res_sum                   = '0;
        res_sum.result_kind       = upte_pkg::KIND_SUMMARY;
        res_sum.source_port       = is_udp ? src_port_next : 16'd0;
        res_sum.frame_is_udp      = is_udp;
        res_sum.frame_segments    = seg_in_frame_next;
        res_sum.capture_abandoned = in_segment_next;
        res_sum.total_segments    = seg_total_next;
        res_sum.total_udp_frames  = udp_total_next;
        res_sum.last_of_run       = 1'b1;

        if (last) begin
            byte_offset_next  = '0;
            ether_type_next   = '0;
            header_words_next = '0;
            ip_protocol_next  = '0;
            udp_length_next   = '0;
            src_port_next     = '0;
            in_segment_next   = 1'b0;
            open_length_next  = '0;
            seg_in_frame_next = '0;
        end

        cell_ctrl.advance = accept;
        cell_ctrl.flush   = first;
        cell_ctrl.shift   = in_pay && !(in_segment_reg && !first);
        cell_ctrl.clear   = tag_open || last;

        push_data0 = has_a ? res_a : res_sum;
        push_count = accept ? (2'(has_a) + 2'(last)) : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_offset_reg  <= '0;
            ether_type_reg   <= '0;
            header_words_reg <= '0;
            ip_protocol_reg  <= '0;
            udp_length_reg   <= '0;
            src_port_reg     <= '0;
            in_segment_reg   <= 1'b0;
            open_length_reg  <= '0;
            seg_in_frame_reg <= '0;
            seg_total_reg    <= '0;
            udp_total_reg    <= '0;
        end else if (accept) begin
            byte_offset_reg  <= byte_offset_next;
            ether_type_reg   <= ether_type_next;
            header_words_reg <= header_words_next;
            ip_protocol_reg  <= ip_protocol_next;
            udp_length_reg   <= udp_length_next;
            src_port_reg     <= src_port_next;
            in_segment_reg   <= in_segment_next;
            open_length_reg  <= open_length_next;
            seg_in_frame_reg <= seg_in_frame_next;
            seg_total_reg    <= seg_total_next;
            udp_total_reg    <= udp_total_next;
        end
    end

    upte_out_fifo u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push_count),
        .push_data0 (push_data0),
        .push_data1 (res_sum),
        .room       (room),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

FILE: src/upte_checker.sv
// Port-level checks for the extractor and the bind that attaches them.
module upte_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input upte_pkg::out_beat_t  m_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // queue is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input side is open right after reset
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // captured bytes carry no segment length and belong to a UDP frame
    a_capture_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.result_kind == upte_pkg::KIND_CAPTURE
        |-> m_data.frame_is_udp && m_data.segment_length == 16'd0
            && m_data.total_segments == 32'd0)
        else $error("capture beat carries stray fields");

    // a non-UDP frame cannot have a port, segments or an open capture
    a_non_udp_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.result_kind == upte_pkg::KIND_SUMMARY && !m_data.frame_is_udp
        |-> m_data.source_port == 16'd0 && m_data.frame_segments == 16'd0
            && !m_data.capture_abandoned && m_data.last_of_run)
        else $error("non-UDP summary carries UDP data");

endmodule

bind udp_payload_tag_extractor_unit upte_checker u_upte_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
